>>> hdl/lnw_pkg.sv
package lnw_pkg;

  // Command and character bytes
  localparam logic [7:0] CmdHome   = 8'h02;
  localparam logic [7:0] CmdLine1  = 8'h80;
  localparam logic [7:0] CmdLine2  = 8'hC0;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharPoint = 8'h2E;

  // Largest value shown; anything above saturates to it
  localparam logic [13:0] ValueCap = 14'd9999;

  // Line codes in the high nibble of place_code
  localparam logic [3:0] LineFirst  = 4'd1;
  localparam logic [3:0] LineSecond = 4'd2;

  // Format codes
  localparam logic [3:0] FmtInt4       = 4'd0;  // dddd
  localparam logic [3:0] FmtFrac1      = 4'd1;  // ddd.d
  localparam logic [3:0] FmtFrac2      = 4'd2;  // dd.dd
  localparam logic [3:0] FmtFrac3      = 4'd3;  // d.ddd
  localparam logic [3:0] FmtInt2       = 4'd4;  // dd
  localparam logic [3:0] FmtFrac1Short = 4'd5;  // d.d
  localparam logic [3:0] FmtInt1       = 4'd6;  // d
  localparam logic [3:0] FmtPoint      = 4'd7;  // lone point
  localparam logic [3:0] FmtNone       = 4'd8;  // commands only

  // Queue between front and back
  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    POS_NONE,
    POS_LINE1,
    POS_LINE2
  } lnw_pos_t;

  // One classified request as held in the queue
  typedef struct packed {
    logic [3:0][3:0] digits;  // index 0 = thousands, 3 = units
    lnw_pos_t        pos;
    logic [3:0]      col;
    logic [3:0]      fmt;     // clamped to FmtNone
  } lnw_item_t;

  // One character slot of a layout
  typedef struct packed {
    logic       is_point;
    logic [1:0] digit_sel;
  } lnw_char_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lnw_q_stat_t;

  // Number of characters a format produces
  function automatic logic [2:0] lnw_char_count(input logic [3:0] fmt);
    logic [2:0] n;
    case (fmt)
      FmtInt4:       n = 3'd4;
      FmtFrac1:      n = 3'd5;
      FmtFrac2:      n = 3'd5;
      FmtFrac3:      n = 3'd5;
      FmtInt2:       n = 3'd2;
      FmtFrac1Short: n = 3'd3;
      FmtInt1:       n = 3'd1;
      FmtPoint:      n = 3'd1;
      default:       n = 3'd0;
    endcase
    return n;
  endfunction

  // Character j of a format's layout
  function automatic lnw_char_t lnw_char_at(input logic [3:0] fmt, input logic [2:0] j);
    lnw_char_t c;
    c.is_point  = 1'b0;
    c.digit_sel = 2'd0;
    case (fmt)
      FmtInt4: c.digit_sel = j[1:0];
      FmtFrac1: begin
        if (j == 3'd3) c.is_point = 1'b1;
        else if (j == 3'd4) c.digit_sel = 2'd3;
        else c.digit_sel = j[1:0];
      end
      FmtFrac2: begin
        if (j == 3'd2) c.is_point = 1'b1;
        else if (j > 3'd2) c.digit_sel = 2'(j - 3'd1);
        else c.digit_sel = j[1:0];
      end
      FmtFrac3: begin
        if (j == 3'd1) c.is_point = 1'b1;
        else if (j > 3'd1) c.digit_sel = 2'(j - 3'd1);
        else c.digit_sel = 2'd0;
      end
      FmtInt2: c.digit_sel = (j == 3'd0) ? 2'd2 : 2'd3;
      FmtFrac1Short: begin
        if (j == 3'd1) c.is_point = 1'b1;
        else c.digit_sel = (j == 3'd0) ? 2'd2 : 2'd3;
      end
      FmtInt1:  c.digit_sel = 2'd3;
      FmtPoint: c.is_point = 1'b1;
      default:  c.digit_sel = 2'd0;
    endcase
    return c;
  endfunction

endpackage

>>> hdl/lnw_if.sv
// Request channel: one number to display
interface lnw_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] value;
  logic [7:0]  place_code;
  logic [3:0]  format;

  modport source (output valid, output value, output place_code, output format,
                  input ready);
  modport sink (input valid, input value, input place_code, input format,
                output ready);
endinterface

// Nibble channel towards the display
interface lnw_out_if;
  logic       valid;
  logic       ready;
  logic       register_select;
  logic [3:0] nibble;
  logic       last_of_run;

  modport source (output valid, output register_select, output nibble,
                  output last_of_run, input ready);
  modport sink (input valid, input register_select, input nibble,
                input last_of_run, output ready);
endinterface

>>> hdl/lnw_front.sv
module lnw_front (
  input  logic              clk,
  input  logic              rst,
  lnw_in_if.sink            req,
  output lnw_pkg::lnw_item_t push_item,
  output logic              push_valid,
  input  logic              push_ready
);
  import lnw_pkg::*;

  logic        s1_valid;
  logic [3:0]  s1_thou;
  logic [9:0]  s1_rem;
  logic [7:0]  s1_place;
  logic [3:0]  s1_fmt;

  logic [13:0] v_sat;
  logic [3:0]  thou;
  logic [13:0] thou_base;
  logic [3:0]  hund;
  logic [9:0]  hund_base;
  logic [6:0]  rem2;
  logic [3:0]  tens;
  logic [6:0]  tens_base;
  logic [3:0]  units;
  logic [3:0]  line;

  // Saturate and take off the thousands digit
  always_comb begin
    v_sat     = (req.value > 16'(ValueCap)) ? ValueCap : req.value[13:0];
    thou      = 4'd0;
    thou_base = 14'd0;
    for (int k = 1; k < 10; k++) begin
      if (v_sat >= 14'(k * 1000)) begin
        thou      = 4'(k);
        thou_base = 14'(k * 1000);
      end
    end
  end

  assign req.ready = !s1_valid || push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
    if (req.valid && req.ready) begin
      s1_thou  <= thou;
      s1_rem   <= 10'(v_sat - thou_base);
      s1_place <= req.place_code;
      s1_fmt   <= req.format;
    end
  end

  // Hundreds, tens and units from the remainder
  always_comb begin
    hund      = 4'd0;
    hund_base = 10'd0;
    for (int k = 1; k < 10; k++) begin
      if (s1_rem >= 10'(k * 100)) begin
        hund      = 4'(k);
        hund_base = 10'(k * 100);
      end
    end
    rem2      = 7'(s1_rem - hund_base);
    tens      = 4'd0;
    tens_base = 7'd0;
    for (int k = 1; k < 10; k++) begin
      if (rem2 >= 7'(k * 10)) begin
        tens      = 4'(k);
        tens_base = 7'(k * 10);
      end
    end
    units = 4'(rem2 - tens_base);
  end

  // Classify place and format
  assign line = s1_place[7:4];

  always_comb begin
    push_item.digits[0] = s1_thou;
    push_item.digits[1] = hund;
    push_item.digits[2] = tens;
    push_item.digits[3] = units;
    push_item.col       = s1_place[3:0];
    push_item.fmt       = (s1_fmt > FmtNone) ? FmtNone : s1_fmt;
    if (line == LineFirst) push_item.pos = POS_LINE1;
    else if (line == LineSecond) push_item.pos = POS_LINE2;
    else push_item.pos = POS_NONE;
  end

  assign push_valid = s1_valid;

endmodule

>>> hdl/lnw_queue.sv
module lnw_queue (
  input  logic               clk,
  input  logic               rst,
  input  lnw_pkg::lnw_item_t push_item,
  input  logic               push_valid,
  output logic               push_ready,
  output lnw_pkg::lnw_item_t head_item,
  output logic               head_valid,
  input  logic               pop,
  output lnw_pkg::lnw_q_stat_t stat
);
  import lnw_pkg::*;

  lnw_item_t        slots [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign stat.full  = (count == QCntW'(QDepth));
  assign stat.empty = (count == '0);
  assign push_ready = !stat.full;
  assign head_valid = !stat.empty;
  assign head_item  = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
    if (do_push) slots[wr_ptr] <= push_item;
  end

endmodule

>>> hdl/lnw_back.sv
module lnw_back (
  input  logic               clk,
  input  logic               rst,
  input  lnw_pkg::lnw_item_t head_item,
  input  logic               head_valid,
  output logic               pop,
  lnw_out_if.source          rsp
);
  import lnw_pkg::*;

  logic [2:0] byte_idx;
  logic       half;
  logic       out_valid;
  logic       out_rs;
  logic [3:0] out_nibble;
  logic       out_last;

  logic       has_pos;
  logic [2:0] last_idx;
  logic [2:0] char_j;
  lnw_char_t  ch;
  logic [7:0] cur_byte;
  logic       cur_rs;
  logic       cur_last;
  logic       adv;

  // Byte currently being sent for the head word
  always_comb begin
    has_pos  = (head_item.pos != POS_NONE);
    last_idx = {2'b00, has_pos} + lnw_char_count(head_item.fmt);
    char_j   = byte_idx - 3'd1 - {2'b00, has_pos};
    ch       = lnw_char_at(head_item.fmt, char_j);
    if (byte_idx == 3'd0) begin
      cur_byte = CmdHome;
      cur_rs   = 1'b0;
    end else if (has_pos && byte_idx == 3'd1) begin
      cur_byte = ((head_item.pos == POS_LINE1) ? CmdLine1 : CmdLine2)
                 | {4'h0, head_item.col};
      cur_rs   = 1'b0;
    end else if (ch.is_point) begin
      cur_byte = CharPoint;
      cur_rs   = 1'b1;
    end else begin
      cur_byte = CharZero | {4'h0, head_item.digits[ch.digit_sel]};
      cur_rs   = 1'b1;
    end
    cur_last = half && (byte_idx == last_idx);
  end

  assign adv = head_valid && (!out_valid || rsp.ready);
  assign pop = adv && cur_last;

  // Nibble sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      byte_idx  <= 3'd0;
      half      <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
      if (cur_last) begin
        byte_idx <= 3'd0;
        half     <= 1'b0;
      end else if (half) begin
        byte_idx <= byte_idx + 3'd1;
        half     <= 1'b0;
      end else begin
        half <= 1'b1;
      end
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (adv) begin
      out_rs     <= cur_rs;
      out_nibble <= half ? cur_byte[3:0] : cur_byte[7:4];
      out_last   <= cur_last;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.register_select = out_rs;
  assign rsp.nibble          = out_nibble;
  assign rsp.last_of_run     = out_last;

endmodule

>>> hdl/lcd_number_nibble_writer.sv
// Number-to-nibble writer for a character display in 4-bit mode.
// req takes one word per number: value, place_code (line code in the high
// nibble, column in the low nibble) and format. rsp gives one nibble per
// word: the home command, an optional position command, then the ASCII
// characters, each byte high nibble first; last_of_run marks the final one.
// Both channels use valid/ready; a word moves when both are high.
// After a request is accepted it passes through the digit stage register
// and the queue into the sequencer's output register, where its first
// nibble appears.
// The output gives one nibble per cycle while rsp.ready is high and a word
// is queued; a request yields 2 to 14 nibbles (2 + 2 for a position + 2 per
// character), and the single nibble sequencer sets the rate. A two-entry queue
// sits between the digit front end and the sequencer, so new requests are
// taken while a run is still going out.
// Reset (rst, synchronous) empties the pipeline and queue; outside reset no
// accepted request is lost. When rsp.ready is low the current nibble holds,
// the queue fills, and req.ready drops once the front stage and queue are full.
module lcd_number_nibble_writer (
  input logic       clk,
  input logic       rst,
  lnw_in_if.sink    req,
  lnw_out_if.source rsp
);
  import lnw_pkg::*;

  lnw_item_t   push_item;
  logic        push_valid;
  logic        push_ready;
  lnw_item_t   head_item;
  logic        head_valid;
  logic        pop;
  lnw_q_stat_t q_stat;

  lnw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .push_item  (push_item),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  lnw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_item  (push_item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .head_item  (head_item),
    .head_valid (head_valid),
    .pop        (pop),
    .stat       (q_stat)
  );

  lnw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_item  (head_item),
    .head_valid (head_valid),
    .pop        (pop),
    .rsp        (rsp)
  );

  // Queue status is never both full and empty
  a_q_stat: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  // The sequencer only retires a word that the queue holds
  a_pop_held: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // Retiring a word puts its final nibble on the output
  a_pop_last: assert property (@(posedge clk) disable iff (rst)
    pop |=> rsp.valid && rsp.last_of_run)
    else $error("retired word without final nibble");

endmodule
